[rtl/ildf_pkg.sv]
// Package for the id/length frame deframer: result kinds, parser phases,
// register indexes, reset limits and the shared payload structs.
// No dependencies.
package ildf_pkg;

   // Header layout: 16-bit id then 16-bit body length, both big-endian.
   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned HDR_COUNT_W  = $clog2(HEADER_BYTES);
   localparam int unsigned HDR_STORE_W  = 8 * (HEADER_BYTES - 1);

   // Control and status register port.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BODY_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MESSAGE_ID  = 1'b1;

   localparam logic [15:0] MAX_BODY_LENGTH_RESET = 16'd2048;
   localparam logic [15:0] MAX_MESSAGE_ID_RESET  = 16'd2048;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   // One result item as it leaves the block.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body_byte;
      logic [15:0] message_id;
      logic        last_of_frame;
   } rsp_type;

   // Header limits from the register file.
   typedef struct packed {
      logic [15:0] max_body_length;
      logic [15:0] max_message_id;
   } limits_type;

endpackage

[rtl/ildf_if.sv]
// Channel interfaces of the id/length frame deframer: received bytes,
// results and register writes. Depends on ildf_pkg.

interface ildf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ildf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  body_byte;
   logic [15:0] message_id;
   logic        last_of_frame;

   modport source (output valid, output kind, output body_byte, output message_id,
                   output last_of_frame, input ready);
   modport sink   (input valid, input kind, input body_byte, input message_id,
                   input last_of_frame, output ready);
endinterface

interface ildf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ildf_pkg::CSR_INDEX_W-1:0] index;
   logic [15:0]                      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/ildf_parser.sv]
// Header parser and body tracker of the id/length frame deframer.
// Holds the frame state and forms at most one result per accepted request.
// Depends on ildf_pkg.
module ildf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           rx_byte,
   input  ildf_pkg::limits_type limits,
   output logic                 result_valid,
   output ildf_pkg::rsp_type    result
);
   import ildf_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [HDR_COUNT_W-1:0]  count_ff, count_in;
   logic [HDR_STORE_W-1:0]  hdr_ff, hdr_in;
   logic [15:0]             frame_id_ff, frame_id_in;
   logic [15:0]             remaining_ff, remaining_in;

   logic [15:0] hdr_id;
   logic [15:0] hdr_len;

   assign hdr_id  = hdr_ff[HDR_STORE_W-1 -: 16];
   assign hdr_len = {hdr_ff[7:0], rx_byte};

   // Control state: phase and header byte count.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Frame payload registers.
   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      frame_id_ff  <= frame_id_in;
      remaining_ff <= remaining_in;
   end

   // Next state and result for the byte presented this cycle.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      hdr_in       = hdr_ff;
      frame_id_in  = frame_id_ff;
      remaining_in = remaining_ff;
      result_valid = 1'b0;
      result       = '{kind: KIND_BODY, body_byte: 8'd0, message_id: frame_id_ff,
                       last_of_frame: 1'b0};
      if (advance) begin
         case (phase_ff)
            PH_HEADER: begin
               if (count_ff != HDR_COUNT_W'(HEADER_BYTES - 1)) begin
                  hdr_in   = {hdr_ff[HDR_STORE_W-9:0], rx_byte};
                  count_in = count_ff + 1'b1;
               end else begin
                  count_in = '0;
                  result.message_id = hdr_id;
                  if (hdr_id > limits.max_message_id ||
                      hdr_len > limits.max_body_length) begin
                     // Bad header: report once, then discard until reset.
                     phase_in     = PH_ERROR;
                     result_valid = 1'b1;
                     result.kind  = KIND_ERROR;
                  end else if (hdr_len == 16'd0) begin
                     frame_id_in          = hdr_id;
                     remaining_in         = 16'd0;
                     result_valid         = 1'b1;
                     result.kind          = KIND_EMPTY;
                     result.last_of_frame = 1'b1;
                  end else begin
                     frame_id_in  = hdr_id;
                     remaining_in = hdr_len;
                     phase_in     = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               result_valid         = 1'b1;
               result.body_byte     = rx_byte;
               result.last_of_frame = (remaining_ff <= 16'd1);
               if (remaining_ff <= 16'd1) begin
                  remaining_in = 16'd0;
                  phase_in     = PH_HEADER;
               end else begin
                  remaining_in = remaining_ff - 16'd1;
               end
            end
            default: begin
               // Error phase: the byte is taken and dropped.
            end
         endcase
      end
   end

endmodule

[rtl/id_length_frame_deframer.sv]
// Top level of the id/length frame deframer. A result appears in the
// cycle after the request that causes it. Throughput: one request per
// cycle; the output register frees the input side whenever it is empty or
// being taken. Reset (synchronous) returns to header gathering, drops any
// pending result and restores both limits to 2048.
module id_length_frame_deframer (
   input logic       clock,
   input logic       reset,
   ildf_req_if.sink   req_ch,
   ildf_rsp_if.source rsp_ch,
   ildf_csr_if.sink   csr_ch
);
   import ildf_pkg::*;

   limits_type limits_ff, limits_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       result_valid;
   rsp_type    result;

   // Limit registers; writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MAX_BODY_LENGTH: limits_in.max_body_length = csr_ch.wdata;
            CSR_MAX_MESSAGE_ID:  limits_in.max_message_id  = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{max_body_length: MAX_BODY_LENGTH_RESET,
                        max_message_id:  MAX_MESSAGE_ID_RESET};
      end else begin
         limits_ff <= limits_in;
      end
   end

   // A request is taken whenever the output register is free this cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   ildf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .rx_byte      (req_ch.rx_byte),
      .limits       (limits_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = result_valid;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_ff.kind;
   assign rsp_ch.body_byte     = rsp_ff.body_byte;
   assign rsp_ch.message_id    = rsp_ff.message_id;
   assign rsp_ch.last_of_frame = rsp_ff.last_of_frame;

   // Only body results carry a data byte.
   a_byte_only_in_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind != KIND_BODY |-> rsp_ff.body_byte == 8'd0)
      else $error("non-body result carries a data byte");

   // An empty frame always closes the frame; an error never does.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.kind == KIND_EMPTY) == rsp_ff.last_of_frame ||
                       rsp_ff.kind == KIND_BODY)
      else $error("last flag disagrees with result kind");

   // A request taken without a result leaves the output register empty.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      accept && !result_valid |=> !rsp_valid_ff)
      else $error("result appeared without a producing request");

endmodule

[tb/tb_id_length_frame_deframer.sv]
`timescale 1ns / 100ps
// Self-checking id/length frame deframer testbench: directed rows, random framed byte
// streams, then closing rows, checked against a predictor. Needs ildf_pkg and ildf_if.

module tb_id_length_frame_deframer;
   import ildf_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam rsp_type NO_RESULT = '{KIND_BODY, 8'h00, 16'h0000, 1'b0};

   typedef enum logic {ROW_BYTE, ROW_CSR} row_op_type;

   // One line of the directed table: a byte request or a limit write.
   typedef struct packed {
      row_op_type             op;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [15:0]            wdata;
      logic [7:0]             rx_byte;
      logic                   given;
      rsp_type                res;
   } stim_row_type;

   logic clock;
   logic reset;

   ildf_req_if req_if ();
   ildf_rsp_if rsp_if ();
   ildf_csr_if csr_if ();

   id_length_frame_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predictor state: header gathering, current frame and the limits.
   phase_type               rx_phase;
   logic [HDR_COUNT_W-1:0]  hdr_count;
   logic [HDR_STORE_W-1:0]  hdr_store;
   logic [15:0]             frame_id;
   logic [15:0]             remaining;
   limits_type              limits;

   rsp_type      pending_results[$];
   stim_row_type stim_table[$];
   int           failures;
   int           idle_cycles;
   int           req_calm;
   int           rsp_calm;
   rsp_type      seen_rsp;
   rsp_type      due_rsp;

   always #6 clock = ~clock;

   function automatic stim_row_type rx_row(input logic [7:0] b);
      stim_row_type row;
      row = '{ROW_BYTE, '0, 16'h0000, b, 1'b0, NO_RESULT};
      return row;
   endfunction

   function automatic stim_row_type rx_row_given(input logic [7:0] b, input kind_type k,
         input logic [7:0] body, input logic [15:0] id, input logic last);
      stim_row_type row;
      row = '{ROW_BYTE, '0, 16'h0000, b, 1'b1, '{k, body, id, last}};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [15:0] data);
      stim_row_type row;
      row = '{ROW_CSR, idx, data, 8'h00, 1'b0, NO_RESULT};
      return row;
   endfunction

   // Idle length for one request on either side; now and then a calm stretch with none.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left = calm_left - 1;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // Works out what the block gives for one received byte.
   task automatic deframe_step(input logic [7:0] b, output bit produced, output rsp_type res);
      logic [15:0] hdr_id;
      logic [15:0] hdr_len;
      produced = 1'b0;
      res = NO_RESULT;
      case (rx_phase)
         PH_HEADER: begin
            if (hdr_count < HEADER_BYTES - 1) begin
               hdr_store = {hdr_store[15:0], b};
               hdr_count = hdr_count + 1'b1;
            end else begin
               hdr_id = hdr_store[23:8];
               hdr_len = {hdr_store[7:0], b};
               hdr_count = '0;
               hdr_store = '0;
               if (hdr_id > limits.max_message_id || hdr_len > limits.max_body_length) begin
                  // A bad header locks the parser until reset.
                  rx_phase = PH_ERROR;
                  produced = 1'b1;
                  res = '{KIND_ERROR, 8'h00, hdr_id, 1'b0};
               end else if (hdr_len == 16'd0) begin
                  frame_id = hdr_id;
                  remaining = 16'd0;
                  produced = 1'b1;
                  res = '{KIND_EMPTY, 8'h00, hdr_id, 1'b1};
               end else begin
                  frame_id = hdr_id;
                  remaining = hdr_len;
                  rx_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            produced = 1'b1;
            res = '{KIND_BODY, b, frame_id, (remaining <= 16'd1)};
            if (remaining <= 16'd1) begin
               remaining = 16'd0;
               rx_phase = PH_HEADER;
            end else begin
               remaining = remaining - 16'd1;
            end
         end
         default: begin
            // Locked after a header error: the byte is swallowed.
         end
      endcase
   endtask

   // Sends one byte request and queues what it should produce.
   task automatic send_byte(input logic [7:0] b, input logic given, input rsp_type res);
      int gap;
      bit produced;
      rsp_type predicted;
      @(negedge clock);
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
      deframe_step(b, produced, predicted);
      if (given)
         pending_results.push_back(res);
      else if (produced)
         pending_results.push_back(predicted);
   endtask

   // Writes one limit once the block has delivered everything that is due.
   task automatic write_limit(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!(csr_if.valid === 1'b1 && csr_if.ready === 1'b1));
      case (idx)
         CSR_MAX_BODY_LENGTH: limits.max_body_length = data;
         CSR_MAX_MESSAGE_ID:  limits.max_message_id = data;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      failures = failures + 1;
      if (failures <= 10)
         $display({"%0t: %s: expected kind %0d byte %02h id %04h last %0b, ",
                   "got kind %0d byte %02h id %04h last %0b"},
                  $realtime, what, want.kind, want.body_byte, want.message_id,
                  want.last_of_frame, got.kind, got.body_byte, got.message_id,
                  got.last_of_frame);
   endtask

   // Compare every accepted result with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen_rsp = '{kind_type'(rsp_if.kind), rsp_if.body_byte, rsp_if.message_id,
                      rsp_if.last_of_frame};
         if (pending_results.size() == 0) begin
            note_failure("result with nothing due", NO_RESULT, seen_rsp);
         end else begin
            due_rsp = pending_results.pop_front();
            if (seen_rsp.kind !== due_rsp.kind || seen_rsp.body_byte !== due_rsp.body_byte
                || seen_rsp.message_id !== due_rsp.message_id
                || seen_rsp.last_of_frame !== due_rsp.last_of_frame)
               note_failure("result mismatch", due_rsp, seen_rsp);
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                   || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                   || (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("id_length_frame_deframer verification failed");
            $finish;
         end
      end
   end

   // Result side: stall for a random while, then take one result.
   initial begin : rsp_drain
      int gap;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
      end
   end

   initial begin : stimulus
      int           i;
      int           tail_start;
      int           random_sent;
      int           phase_end;
      int           cap;
      int           frame_len;
      logic [15:0]  lim_len;
      logic [15:0]  lim_id;
      logic [15:0]  hdr_id;
      stim_row_type row;

      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_MAX_BODY_LENGTH;
      csr_if.wdata = 16'h0000;
      failures = 0;
      req_calm = 0;
      rsp_calm = 0;

      rx_phase = PH_HEADER;
      hdr_count = '0;
      hdr_store = '0;
      frame_id = 16'h0000;
      remaining = 16'h0000;
      limits = '{MAX_BODY_LENGTH_RESET, MAX_MESSAGE_ID_RESET};

      // Empty frame with the id right at its reset limit.
      stim_table.push_back(rx_row(8'h08));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row_given(8'h00, KIND_EMPTY, 8'h00, 16'h0800, 1'b1));
      // Smallest id with a one-byte body of all ones.
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h01));
      stim_table.push_back(rx_row_given(8'hFF, KIND_BODY, 8'hFF, 16'h0000, 1'b1));
      // Three-byte body.
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h01));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h03));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h80));
      stim_table.push_back(rx_row(8'h7F));
      // Widest limits, then the largest id; the limits drop to zero mid-frame
      // and must only bite from the next header on.
      stim_table.push_back(csr_row(CSR_MAX_BODY_LENGTH, 16'hFFFF));
      stim_table.push_back(csr_row(CSR_MAX_MESSAGE_ID, 16'hFFFF));
      stim_table.push_back(rx_row(8'hFF));
      stim_table.push_back(rx_row(8'hFF));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h02));
      stim_table.push_back(csr_row(CSR_MAX_BODY_LENGTH, 16'h0000));
      stim_table.push_back(csr_row(CSR_MAX_MESSAGE_ID, 16'h0000));
      stim_table.push_back(rx_row_given(8'hAA, KIND_BODY, 8'hAA, 16'hFFFF, 1'b0));
      stim_table.push_back(rx_row_given(8'h55, KIND_BODY, 8'h55, 16'hFFFF, 1'b1));
      // Zero limits still pass an all-zero header.
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row_given(8'h00, KIND_EMPTY, 8'h00, 16'h0000, 1'b1));
      tail_start = stim_table.size();
      // Closing rows: both limits exceeded gives one error, then all is discarded.
      stim_table.push_back(csr_row(CSR_MAX_BODY_LENGTH, 16'd100));
      stim_table.push_back(csr_row(CSR_MAX_MESSAGE_ID, 16'd100));
      stim_table.push_back(rx_row(8'hFF));
      stim_table.push_back(rx_row(8'hFF));
      stim_table.push_back(rx_row(8'hFF));
      stim_table.push_back(rx_row_given(8'hFF, KIND_ERROR, 8'h00, 16'hFFFF, 1'b0));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'h00));
      stim_table.push_back(rx_row(8'hFF));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < stim_table.size(); i++) begin
         if (i == tail_start) begin
            // Random part: well-formed frames under a series of limit settings.
            random_sent = 0;
            while (random_sent < RANDOM_ITEMS) begin
               case ($urandom_range(0, 3))
                  0: begin
                     lim_len = 16'hFFFF;
                     lim_id = 16'hFFFF;
                  end
                  1: begin
                     lim_len = 16'h0000;
                     lim_id = 16'h0000;
                  end
                  2: begin
                     lim_len = 16'd1;
                     lim_id = 16'd1;
                  end
                  default: begin
                     lim_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 64))
                                                    : 16'($urandom_range(0, 65535));
                     lim_id = 16'($urandom_range(0, 65535));
                  end
               endcase
               write_limit(CSR_MAX_BODY_LENGTH, lim_len);
               write_limit(CSR_MAX_MESSAGE_ID, lim_id);
               phase_end = random_sent + $urandom_range(40, 120);
               while (random_sent < phase_end) begin
                  hdr_id = ($urandom_range(0, 7) == 0) ? lim_id
                                                       : 16'($urandom_range(0, lim_id));
                  cap = ($urandom_range(0, 15) == 0) ? 300 : 24;
                  if (cap > int'(lim_len))
                     cap = int'(lim_len);
                  frame_len = ($urandom_range(0, 7) == 0) ? cap : $urandom_range(0, cap);
                  send_byte(hdr_id[15:8], 1'b0, NO_RESULT);
                  send_byte(hdr_id[7:0], 1'b0, NO_RESULT);
                  send_byte(frame_len[15:8], 1'b0, NO_RESULT);
                  send_byte(frame_len[7:0], 1'b0, NO_RESULT);
                  repeat (frame_len) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
                  random_sent = random_sent + 4 + frame_len;
               end
            end
         end
         row = stim_table[i];
         if (row.op == ROW_CSR)
            write_limit(row.csr_index, row.wdata);
         else
            send_byte(row.rx_byte, row.given, row.res);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      while (pending_results.size() != 0)
         note_failure("result never delivered", pending_results.pop_front(), NO_RESULT);
      if (failures == 0)
         $display("id_length_frame_deframer verification clean");
      else
         $display("id_length_frame_deframer verification failed");
      $finish;
   end

endmodule
